// ===== hw/rtl/rati_pkg.sv =====
package rati_pkg;

    // Breakpoint store and cosine table sizes
    localparam int MAX_POINTS      = 16;
    localparam int SLOT_W          = 4;
    localparam int CNT_W           = 5;
    localparam int COS_TABLE_DEPTH = 256;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH + 1);

    // Field widths
    localparam int RAD_W  = 24;
    localparam int ANG_W  = 16;
    localparam int TEMP_W = 24;

    // Divider: 42-bit dividend, two quotient bits per cycle
    localparam int DIVD_W    = 42;
    localparam int DIVS_W    = 18;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DIVC_W    = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_RIM_MODE     = 3'd0;
    localparam logic [2:0] REG_OUTER_RADIUS = 3'd1;
    localparam logic [2:0] REG_RIM_WIDTH    = 3'd2;
    localparam logic [2:0] REG_PEAK_TEMP    = 3'd3;
    localparam logic [2:0] REG_FLOOR_TEMP   = 3'd4;
    localparam logic [2:0] REG_PEAK_ANGLE   = 3'd5;
    localparam logic [2:0] REG_POINT_COUNT  = 3'd6;

    // Input function codes
    localparam logic FUNC_EVAL  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Profile modes
    localparam logic MODE_SINE  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    // Item kind after classification
    typedef enum logic [1:0] {
        K_WRITE,
        K_OUTSIDE,
        K_SINE,
        K_POINT
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [ANG_W-1:0]    angle;
        logic [SLOT_W-1:0]   slot;
        logic [ANG_W-1:0]    pangle;
        logic [TEMP_W-1:0]   ptemp;
    } t_item;

    // Settings the back end uses
    typedef struct packed {
        logic [TEMP_W-1:0] peak_temp;
        logic [TEMP_W-1:0] floor_temp;
        logic [ANG_W-1:0]  peak_angle;
        logic [CNT_W-1:0]  point_count;
    } t_back_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIN_LOOK,
        S_SIN_MUL,
        S_SIN_SUM,
        S_PT_FIRST,
        S_PT_SCAN,
        S_PT_WRAP,
        S_PT_MUL,
        S_PT_VAL,
        S_PT_DIV,
        S_PT_FIX,
        S_DONE
    } t_state;

    // Quarter-wave cosine table, Q16, built at elaboration from a Taylor series
    typedef logic [16:0] t_cos_tab [0:COS_TABLE_DEPTH];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam longint unsigned TAYLOR_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    function automatic t_cos_tab f_build_cos();
        t_cos_tab          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   v;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (longint'(sum) + 8192) >> 14;
            if (v > 65536) begin
                v = 65536;
            end
            tab[k] = v[16:0];
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_Q16 = f_build_cos();

endpackage

// ===== hw/rtl/rim_angle_temperature_interp.sv =====
// Rim temperature lookup by radius and azimuth.
// Input stream (s_axis): tuser = func (0 evaluate, 1 write breakpoint);
// tdata carries radius, angle, point_slot, point_angle, point_temp.
// Output stream (m_axis): one result per input transaction; tdata holds
// temperature, tuser holds status (1 = no breakpoint segment matched).
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data, written when idle.
// A two-entry queue sits between the classifying front end and the
// sequencer, so input is taken while a result waits in the output register.
// Steps: writes and out-of-band evaluates go straight to the done state;
// single-point evaluates read the first breakpoint; sinusoid evaluates pass
// lookup, multiply and sum; point evaluates run the breakpoint scan (one
// memory read per cycle), multiply, value, the radix-4 divider and a fix.
// One item is worked at a time; the next leaves the queue once the last is out.
// Reset: registers return to their reset values, queue and output empty;
// breakpoints hold no value until written.
// A stalled receiver holds the result; the sequencer finishes one more and
// the queue fills, so tready falls after three more transactions.
module rim_angle_temperature_interp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: radius[23:0], angle[39:24], point_slot[43:40],
    //        point_angle[59:44], point_temp[83:60], zero fill[87:84]
    input  logic [87:0]  s_axis_tdata,
    // tuser: func[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: temperature[23:0]
    output logic [23:0]  m_axis_tdata,
    // tuser: status[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    logic        r_rim_mode;
    logic [23:0] r_outer_radius;
    logic [23:0] r_rim_width;
    logic [23:0] r_peak_temp;
    logic [23:0] r_floor_temp;
    logic [15:0] r_peak_angle;
    logic [4:0]  r_point_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rim_mode     <= 1'b0;
            r_outer_radius <= 24'hFFFFFF;
            r_rim_width    <= '0;
            r_peak_temp    <= '0;
            r_floor_temp   <= '0;
            r_peak_angle   <= '0;
            r_point_count  <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rati_pkg::REG_RIM_MODE:     r_rim_mode     <= i_cfg_data[0];
                rati_pkg::REG_OUTER_RADIUS: r_outer_radius <= i_cfg_data;
                rati_pkg::REG_RIM_WIDTH:    r_rim_width    <= i_cfg_data;
                rati_pkg::REG_PEAK_TEMP:    r_peak_temp    <= i_cfg_data;
                rati_pkg::REG_FLOOR_TEMP:   r_floor_temp   <= i_cfg_data;
                rati_pkg::REG_PEAK_ANGLE:   r_peak_angle   <= i_cfg_data[15:0];
                rati_pkg::REG_POINT_COUNT:  r_point_count  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    rati_pkg::t_item     w_push_item;
    rati_pkg::t_item     w_q_item;
    rati_pkg::t_back_cfg w_back_cfg;
    logic                w_push;
    logic                w_full;
    logic                w_pop;
    logic                w_q_valid;

    assign w_back_cfg = '{peak_temp:   r_peak_temp,
                          floor_temp:  r_floor_temp,
                          peak_angle:  r_peak_angle,
                          point_count: r_point_count};

    rati_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_radius       (s_axis_tdata[23:0]),
        .i_angle        (s_axis_tdata[39:24]),
        .i_point_slot   (s_axis_tdata[43:40]),
        .i_point_angle  (s_axis_tdata[59:44]),
        .i_point_temp   (s_axis_tdata[83:60]),
        .i_rim_mode     (r_rim_mode),
        .i_outer_radius (r_outer_radius),
        .i_rim_width    (r_rim_width),
        .o_push         (w_push),
        .o_item         (w_push_item),
        .i_full         (w_full)
    );

    rati_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    rati_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_back_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_temperature (m_axis_tdata),
        .o_status      (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/rati_front.sv =====
module rati_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic [rati_pkg::RAD_W-1:0]        i_radius,
    input  logic [rati_pkg::ANG_W-1:0]        i_angle,
    input  logic [rati_pkg::SLOT_W-1:0]       i_point_slot,
    input  logic [rati_pkg::ANG_W-1:0]        i_point_angle,
    input  logic [rati_pkg::TEMP_W-1:0]       i_point_temp,
    input  logic                              i_rim_mode,
    input  logic [rati_pkg::RAD_W-1:0]        i_outer_radius,
    input  logic [rati_pkg::RAD_W-1:0]        i_rim_width,
    output logic                              o_push,
    output rati_pkg::t_item                   o_item,
    input  logic                              i_full
);

    logic signed [rati_pkg::RAD_W+1:0] w_inner;
    logic signed [rati_pkg::RAD_W+1:0] w_rad;
    logic                              w_in_rim;

    // Radial band check, inner bound may go below zero
    always_comb begin
        w_inner  = $signed({2'b00, i_outer_radius}) - $signed({2'b00, i_rim_width});
        w_rad    = $signed({2'b00, i_radius});
        w_in_rim = (w_rad >= w_inner) && (i_radius <= i_outer_radius);
    end

    // Classify the transaction
    always_comb begin
        o_item.angle  = i_angle;
        o_item.slot   = i_point_slot;
        o_item.pangle = i_point_angle;
        o_item.ptemp  = i_point_temp;
        priority if (i_func == rati_pkg::FUNC_WRITE) begin
            o_item.kind = rati_pkg::K_WRITE;
        end else if (!w_in_rim) begin
            o_item.kind = rati_pkg::K_OUTSIDE;
        end else if (i_rim_mode == rati_pkg::MODE_SINE) begin
            o_item.kind = rati_pkg::K_SINE;
        end else begin
            o_item.kind = rati_pkg::K_POINT;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // A push never lands on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full queue");

    // Writes are never classified by radius
    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_func == rati_pkg::FUNC_WRITE) |-> o_item.kind == rati_pkg::K_WRITE)
        else $error("write misclassified");

    // Out-of-band evaluates never go to a profile unit
    a_out_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_func == rati_pkg::FUNC_EVAL && i_radius > i_outer_radius)
        |-> o_item.kind == rati_pkg::K_OUTSIDE) else $error("outside radius misclassified");

endmodule

// ===== hw/rtl/rati_queue.sv =====
module rati_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rati_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rati_pkg::t_item o_item
);

    rati_pkg::t_item r_mem [0:1];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/rati_back.sv =====
module rati_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rati_pkg::t_back_cfg            i_cfg,
    input  logic                           i_q_valid,
    input  rati_pkg::t_item                i_q_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rati_pkg::TEMP_W-1:0]    o_temperature,
    output logic                           o_status
);

    localparam int TW = rati_pkg::TEMP_W;
    localparam int AW = rati_pkg::ANG_W;
    localparam int BPW = AW + TW;

    rati_pkg::t_state r_state;
    rati_pkg::t_state n_state;

    // Breakpoint memory {angle, temp}
    logic [BPW-1:0]              r_bp_mem [0:rati_pkg::MAX_POINTS-1];
    logic [BPW-1:0]              r_rd_data;
    logic [rati_pkg::SLOT_W-1:0] w_rd_addr;

    // Working registers
    logic [AW-1:0]               r_angle;
    logic [rati_pkg::SLOT_W-1:0] r_idx;
    logic [BPW-1:0]              r_first;
    logic [BPW-1:0]              r_prev;
    logic [AW:0]                 r_span;
    logic [AW:0]                 r_m;
    logic [TW-1:0]               r_tlo;
    logic                        r_neg;
    logic [TW-1:0]               r_mag;
    logic [rati_pkg::DIVD_W-1:0] r_prod;
    logic [rati_pkg::DIVD_W-1:0] r_quo;
    logic [rati_pkg::DIVS_W:0]   r_rem;
    logic [rati_pkg::DIVC_W-1:0] r_cnt;
    logic signed [17:0]          r_cos;
    logic signed [42:0]          r_sprod;
    logic [TW-1:0]               r_res_temp;
    logic                        r_res_status;
    logic                        r_out_valid;
    logic [TW-1:0]               r_out_temp;
    logic                        r_out_status;

    // Next-value signals
    logic [rati_pkg::SLOT_W-1:0] n_idx;
    logic                        w_load;
    logic                        w_seg_hit;
    logic                        w_wrap_hit;
    logic [rati_pkg::CNT_W-1:0]  w_n;
    logic [rati_pkg::SLOT_W-1:0] w_last;
    logic [AW-1:0]               w_cur_a;
    logic [AW-1:0]               w_prev_a;
    logic [rati_pkg::CNT_W-1:0]  w_pc;

    // Point count clamped to 1..MAX_POINTS
    always_comb begin
        w_pc = i_cfg.point_count;
        if (w_pc == '0) begin
            w_n = rati_pkg::CNT_W'(1);
        end else if (w_pc > rati_pkg::CNT_W'(rati_pkg::MAX_POINTS)) begin
            w_n = rati_pkg::CNT_W'(rati_pkg::MAX_POINTS);
        end else begin
            w_n = w_pc;
        end
        w_last = rati_pkg::SLOT_W'(w_n - rati_pkg::CNT_W'(1));
    end

    assign w_cur_a    = r_rd_data[BPW-1:TW];
    assign w_prev_a   = r_prev[BPW-1:TW];
    assign w_seg_hit  = (r_angle >= w_prev_a) && (r_angle < w_cur_a);
    assign w_wrap_hit = (r_angle >= w_prev_a);
    assign w_load     = (!r_out_valid) || i_ready;

    // Memory read address follows the scan
    always_comb begin
        unique case (r_state)
            rati_pkg::S_PT_FIRST: w_rd_addr = rati_pkg::SLOT_W'(1);
            rati_pkg::S_PT_SCAN:  w_rd_addr = r_idx + rati_pkg::SLOT_W'(1);
            default:              w_rd_addr = '0;
        endcase
    end

    // Breakpoint memory
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_item.kind == rati_pkg::K_WRITE) begin
            r_bp_mem[i_q_item.slot] <= {i_q_item.pangle, i_q_item.ptemp};
        end
        r_rd_data <= r_bp_mem[w_rd_addr];
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        n_idx   = r_idx;
        unique case (r_state)
            rati_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                    unique case (i_q_item.kind)
                        rati_pkg::K_SINE:  n_state = rati_pkg::S_SIN_LOOK;
                        rati_pkg::K_POINT: n_state = rati_pkg::S_PT_FIRST;
                        default:           n_state = rati_pkg::S_DONE;
                    endcase
                end
            end
            rati_pkg::S_SIN_LOOK: n_state = rati_pkg::S_SIN_MUL;
            rati_pkg::S_SIN_MUL:  n_state = rati_pkg::S_SIN_SUM;
            rati_pkg::S_SIN_SUM:  n_state = rati_pkg::S_DONE;
            rati_pkg::S_PT_FIRST: begin
                if (w_n == rati_pkg::CNT_W'(1)) begin
                    n_state = rati_pkg::S_DONE;
                end else begin
                    n_idx   = rati_pkg::SLOT_W'(1);
                    n_state = rati_pkg::S_PT_SCAN;
                end
            end
            rati_pkg::S_PT_SCAN: begin
                if (w_seg_hit) begin
                    n_state = rati_pkg::S_PT_MUL;
                end else if (r_idx == w_last) begin
                    n_state = rati_pkg::S_PT_WRAP;
                end else begin
                    n_idx = r_idx + rati_pkg::SLOT_W'(1);
                end
            end
            rati_pkg::S_PT_WRAP: begin
                n_state = w_wrap_hit ? rati_pkg::S_PT_MUL : rati_pkg::S_DONE;
            end
            rati_pkg::S_PT_MUL: n_state = rati_pkg::S_PT_VAL;
            rati_pkg::S_PT_VAL: n_state = rati_pkg::S_PT_DIV;
            rati_pkg::S_PT_DIV: begin
                if (r_cnt == rati_pkg::DIVC_W'(rati_pkg::DIV_STEPS - 1)) begin
                    n_state = rati_pkg::S_PT_FIX;
                end
            end
            rati_pkg::S_PT_FIX: n_state = rati_pkg::S_DONE;
            rati_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = rati_pkg::S_IDLE;
                end
            end
            default: n_state = rati_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rati_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cosine lookup terms
    logic [AW-1:0]                 w_d;
    logic [31:0]                   w_iraw;
    logic [rati_pkg::COS_IDX_W-1:0] w_i;
    logic [rati_pkg::COS_IDX_W-1:0] w_j;
    logic signed [17:0]            w_cos;
    always_comb begin
        w_d    = r_angle - i_cfg.peak_angle;
        w_iraw = (32'(w_d[13:0]) * 32'(rati_pkg::COS_TABLE_DEPTH) + 32'd8192) >> 14;
        if (w_iraw > 32'(rati_pkg::COS_TABLE_DEPTH)) begin
            w_iraw = 32'(rati_pkg::COS_TABLE_DEPTH);
        end
        w_i = w_iraw[rati_pkg::COS_IDX_W-1:0];
        w_j = rati_pkg::COS_IDX_W'(rati_pkg::COS_TABLE_DEPTH) - w_i;
        unique case (w_d[15:14])
            2'd0:    w_cos =  $signed({1'b0, rati_pkg::COS_Q16[w_i]});
            2'd1:    w_cos = -$signed({1'b0, rati_pkg::COS_Q16[w_j]});
            2'd2:    w_cos = -$signed({1'b0, rati_pkg::COS_Q16[w_i]});
            default: w_cos =  $signed({1'b0, rati_pkg::COS_Q16[w_j]});
        endcase
    end

    // Sinusoid sum, rounding and clamp
    logic signed [24:0] w_pf_diff;
    logic signed [45:0] w_num;
    logic [45:0]        w_sh;
    logic [TW-1:0]      w_sin_t;
    always_comb begin
        w_pf_diff = $signed({1'b0, i_cfg.peak_temp}) - $signed({1'b0, i_cfg.floor_temp});
        w_num = $signed({5'd0, ({1'b0, i_cfg.peak_temp} + {1'b0, i_cfg.floor_temp}), 16'd0})
              + 46'(r_sprod);
        w_sh  = (46'(w_num) + 46'd65536) >> 17;
        if (w_num < 0) begin
            w_sin_t = '0;
        end else if (w_sh > 46'(24'hFFFFFF)) begin
            w_sin_t = '1;
        end else begin
            w_sin_t = w_sh[TW-1:0];
        end
    end

    // Divider step pair
    logic [rati_pkg::DIVS_W-1:0] w_dvs;
    logic [rati_pkg::DIVS_W:0]   w_r1;
    logic [rati_pkg::DIVS_W:0]   w_r2;
    logic                        w_q1;
    logic                        w_q2;
    always_comb begin
        w_dvs = {r_span, 1'b0};
        w_r1  = {r_rem[rati_pkg::DIVS_W-1:0], r_quo[rati_pkg::DIVD_W-1]};
        w_q1  = (w_r1 >= {1'b0, w_dvs});
        if (w_q1) begin
            w_r1 = w_r1 - {1'b0, w_dvs};
        end
        w_r2  = {w_r1[rati_pkg::DIVS_W-1:0], r_quo[rati_pkg::DIVD_W-2]};
        w_q2  = (w_r2 >= {1'b0, w_dvs});
        if (w_q2) begin
            w_r2 = w_r2 - {1'b0, w_dvs};
        end
    end

    // Value before division and final correction
    logic signed [43:0] w_v;
    logic [25:0]        w_qmag;
    logic signed [27:0] w_t;
    always_comb begin
        if (r_neg) begin
            w_v = $signed({1'b0, 26'd0, r_span}) - $signed({2'b00, r_prod});
        end else begin
            w_v = $signed({1'b0, 26'd0, r_span}) + $signed({2'b00, r_prod});
        end
        w_qmag = r_quo[25:0] + 26'(r_neg && (r_rem != '0));
        if (r_neg) begin
            w_t = $signed({4'd0, r_tlo}) - $signed({2'b00, w_qmag});
        end else begin
            w_t = $signed({4'd0, r_tlo}) + $signed({2'b00, w_qmag});
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        unique case (r_state)
            rati_pkg::S_IDLE: begin
                r_angle      <= i_q_item.angle;
                r_res_temp   <= '0;
                r_res_status <= 1'b0;
            end
            rati_pkg::S_SIN_LOOK: r_cos <= w_cos;
            rati_pkg::S_SIN_MUL:  r_sprod <= 43'(w_pf_diff * r_cos);
            rati_pkg::S_SIN_SUM:  r_res_temp <= w_sin_t;
            rati_pkg::S_PT_FIRST: begin
                r_first    <= r_rd_data;
                r_prev     <= r_rd_data;
                r_res_temp <= r_rd_data[TW-1:0];
            end
            rati_pkg::S_PT_SCAN: begin
                r_prev <= r_rd_data;
                r_span <= {1'b0, w_cur_a} - {1'b0, w_prev_a};
                r_m    <= {1'b0, r_angle} - {1'b0, w_prev_a};
                r_tlo  <= r_prev[TW-1:0];
                r_neg  <= (r_rd_data[TW-1:0] < r_prev[TW-1:0]);
                r_mag  <= (r_rd_data[TW-1:0] < r_prev[TW-1:0])
                        ? r_prev[TW-1:0] - r_rd_data[TW-1:0]
                        : r_rd_data[TW-1:0] - r_prev[TW-1:0];
            end
            rati_pkg::S_PT_WRAP: begin
                r_span <= (AW+1)'(1 << AW) - {1'b0, w_prev_a};
                r_m    <= {1'b0, r_angle} - {1'b0, w_prev_a};
                r_tlo  <= r_prev[TW-1:0];
                r_neg  <= (r_first[TW-1:0] < r_prev[TW-1:0]);
                r_mag  <= (r_first[TW-1:0] < r_prev[TW-1:0])
                        ? r_prev[TW-1:0] - r_first[TW-1:0]
                        : r_first[TW-1:0] - r_prev[TW-1:0];
                // no segment matched: zero temperature with status set
                if (!w_wrap_hit) begin
                    r_res_temp   <= '0;
                    r_res_status <= 1'b1;
                end
            end
            rati_pkg::S_PT_MUL: r_prod <= {41'(r_mag * r_m), 1'b0};
            rati_pkg::S_PT_VAL: begin
                r_neg <= w_v < 0;
                r_quo <= (w_v < 0) ? rati_pkg::DIVD_W'(-w_v) : rati_pkg::DIVD_W'(w_v);
                r_rem <= '0;
                r_cnt <= '0;
            end
            rati_pkg::S_PT_DIV: begin
                r_rem <= w_r2;
                r_quo <= {r_quo[rati_pkg::DIVD_W-3:0], w_q1, w_q2};
                r_cnt <= r_cnt + rati_pkg::DIVC_W'(1);
            end
            rati_pkg::S_PT_FIX: begin
                if (w_t < 0) begin
                    r_res_temp <= '0;
                end else if (w_t > $signed(28'(24'hFFFFFF))) begin
                    r_res_temp <= '1;
                end else begin
                    r_res_temp <= w_t[TW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rati_pkg::S_DONE && w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rati_pkg::S_DONE && w_load) begin
            r_out_temp   <= r_res_temp;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_temperature = r_out_temp;
    assign o_status      = r_out_status;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> r_out_temp == '0)
        else $error("no-segment result carries a temperature");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == rati_pkg::S_IDLE) else $error("pop while busy");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rati_pkg::S_PT_DIV |-> r_cnt < rati_pkg::DIVC_W'(rati_pkg::DIV_STEPS))
        else $error("divider overran");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rati_pkg::S_PT_SCAN |-> (r_idx != '0 && r_idx <= w_last))
        else $error("scan index out of range");

endmodule

// ===== tb/tb_rim_angle_temperature_interp.sv =====
`timescale 1ns / 100ps

module tb_rim_angle_temperature_interp;

    // Rim temperature prediction and result queue
    class rim_temp_scoreboard;
        typedef struct {
            logic [rati_pkg::TEMP_W-1:0] temp;
            logic                        status;
        } t_rim_result;

        t_rim_result                 want_q[$];
        int unsigned                 n_mismatch;
        int unsigned                 n_checked;
        int unsigned                 n_sine;
        int unsigned                 n_point;
        int unsigned                 n_nomatch;
        logic                        mode;
        logic [rati_pkg::RAD_W-1:0]  outer_r;
        logic [rati_pkg::RAD_W-1:0]  band_w;
        logic [rati_pkg::TEMP_W-1:0] hot_t;
        logic [rati_pkg::TEMP_W-1:0] cold_t;
        logic [rati_pkg::ANG_W-1:0]  hot_ang;
        logic [rati_pkg::CNT_W-1:0]  n_pts;
        logic [rati_pkg::ANG_W-1:0]  pt_ang [rati_pkg::MAX_POINTS];
        logic [rati_pkg::TEMP_W-1:0] pt_temp [rati_pkg::MAX_POINTS];
        longint                      cos_tab [rati_pkg::COS_TABLE_DEPTH+1];

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            mode    = rati_pkg::MODE_SINE;
            outer_r = '1;
            band_w  = '0;
            hot_t   = '0;
            cold_t  = '0;
            hot_ang = '0;
            n_pts   = rati_pkg::CNT_W'(1);
            // quarter-wave cosine, Taylor series in Q30, rounded to Q16
            for (int k = 0; k <= rati_pkg::COS_TABLE_DEPTH; k++) begin
                x    = (longint'(k) * 64'd1686629713) / rati_pkg::COS_TABLE_DEPTH;
                x2   = (x * x) >> 30;
                term = 64'd1073741824;
                acc  = 64'sd1073741824;
                for (int n = 1; n <= 8; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                    acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
                end
                if (acc < 0) acc = 0;
                acc = (acc + 8192) >>> 14;
                cos_tab[k] = (acc > 65536) ? 65536 : acc;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                rati_pkg::REG_RIM_MODE:     mode    = val[0];
                rati_pkg::REG_OUTER_RADIUS: outer_r = val;
                rati_pkg::REG_RIM_WIDTH:    band_w  = val;
                rati_pkg::REG_PEAK_TEMP:    hot_t   = val;
                rati_pkg::REG_FLOOR_TEMP:   cold_t  = val;
                rati_pkg::REG_PEAK_ANGLE:   hot_ang = val[15:0];
                rati_pkg::REG_POINT_COUNT:  n_pts   = val[4:0];
                default: ;
            endcase
        endfunction

        function longint sine_temp(logic [rati_pkg::ANG_W-1:0] ang);
            logic [rati_pkg::ANG_W-1:0] ph;
            longint                     idx;
            longint                     c;
            longint                     num;
            ph  = ang - hot_ang;
            idx = (longint'(ph[13:0]) * rati_pkg::COS_TABLE_DEPTH + 8192) >>> 14;
            case (ph[15:14])
                2'd0: c = cos_tab[idx];
                2'd1: c = -cos_tab[rati_pkg::COS_TABLE_DEPTH - idx];
                2'd2: c = -cos_tab[idx];
                default: c = cos_tab[rati_pkg::COS_TABLE_DEPTH - idx];
            endcase
            num = (longint'(hot_t) + longint'(cold_t)) * 65536
                + (longint'(hot_t) - longint'(cold_t)) * c;
            if (num < 0) return 0;
            num = (num + 65536) >>> 17;
            return (num > 64'hFFFFFF) ? 64'hFFFFFF : num;
        endfunction

        function longint point_interp(logic [rati_pkg::ANG_W-1:0] ang, output logic miss);
            int     n;
            longint a;
            longint lo;
            longint hi;
            longint tlo;
            longint thi;
            longint span;
            longint v;
            longint q;
            longint t;
            miss = 1'b0;
            a    = longint'(ang);
            n = (n_pts == 0) ? 1 : ((n_pts > rati_pkg::MAX_POINTS) ? rati_pkg::MAX_POINTS
                                                                   : int'(n_pts));
            if (n == 1) return longint'(pt_temp[0]);
            for (int i = 0; i < n; i++) begin
                lo  = longint'(pt_ang[i]);
                tlo = longint'(pt_temp[i]);
                // last segment wraps to the first point at a full turn
                hi  = (i + 1 < n) ? longint'(pt_ang[i+1]) : 65536;
                thi = (i + 1 < n) ? longint'(pt_temp[i+1]) : longint'(pt_temp[0]);
                if (a >= lo && a < hi) begin
                    span = hi - lo;
                    v = 2 * (thi - tlo) * (a - lo) + span;
                    q = (v >= 0) ? v / (2 * span) : -((-v + 2 * span - 1) / (2 * span));
                    t = tlo + q;
                    if (t < 0) t = 0;
                    if (t > 64'hFFFFFF) t = 64'hFFFFFF;
                    return t;
                end
            end
            miss = 1'b1;
            return 0;
        endfunction

        function void note_item(logic func, logic [87:0] d);
            t_rim_result                r;
            longint                     inner;
            logic [rati_pkg::RAD_W-1:0] rad;
            r.temp   = '0;
            r.status = 1'b0;
            rad      = d[23:0];
            if (func == rati_pkg::FUNC_WRITE) begin
                pt_ang[d[43:40]]  = d[59:44];
                pt_temp[d[43:40]] = d[83:60];
            end else begin
                // inner bound may fall below zero
                inner = longint'(outer_r) - longint'(band_w);
                if (longint'(rad) >= inner && rad <= outer_r) begin
                    if (mode == rati_pkg::MODE_SINE) begin
                        r.temp = rati_pkg::TEMP_W'(sine_temp(d[39:24]));
                        n_sine++;
                    end else begin
                        r.temp = rati_pkg::TEMP_W'(point_interp(d[39:24], r.status));
                        n_point++;
                        if (r.status) n_nomatch++;
                    end
                end
            end
            want_q.push_back(r);
        endfunction

        function void check_result(logic [rati_pkg::TEMP_W-1:0] temp, logic status);
            t_rim_result r;
            n_checked++;
            if (want_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result temp=%0d status=%0d", temp, status);
                return;
            end
            r = want_q.pop_front();
            if (temp !== r.temp || status !== r.status) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch #%0d: temp exp %0d got %0d, status exp %0d got %0d",
                             n_checked, r.temp, temp, r.status, status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [87:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = rati_pkg::REG_RIM_MODE;
    logic [23:0] cfg_data = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    rim_temp_scoreboard sb = new();
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int unsigned n_sent = 0;
    int unsigned n_cfg = 0;

    rim_angle_temperature_interp u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    // 24-bit value with the extremes weighted up
    function automatic logic [23:0] rnd24();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap() - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_ready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_item(input logic func, input logic [rati_pkg::RAD_W-1:0] rad,
                             input logic [rati_pkg::ANG_W-1:0] ang, input logic [3:0] slot,
                             input logic [rati_pkg::ANG_W-1:0] pang,
                             input logic [rati_pkg::TEMP_W-1:0] ptemp);
        int          gap;
        logic [87:0] d;
        d   = {4'b0, ptemp, pang, slot, ang, rad};
        gap = (no_idle || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_user  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, d);
        n_sent++;
    endtask

    task automatic eval_at(input logic [rati_pkg::RAD_W-1:0] rad,
                           input logic [rati_pkg::ANG_W-1:0] ang);
        send_item(rati_pkg::FUNC_EVAL, rad, ang, 4'($urandom), 16'($urandom), 24'($urandom));
    endtask

    task automatic load_point(input logic [3:0] slot, input logic [rati_pkg::ANG_W-1:0] pang,
                              input logic [rati_pkg::TEMP_W-1:0] ptemp);
        send_item(rati_pkg::FUNC_WRITE, 24'($urandom), 16'($urandom), slot, pang, ptemp);
    endtask

    // sender holds off until every result is back and the block is quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // caller lowers the enable after the last write of a group
    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        n_cfg++;
    endtask

    // breakpoint set: first n ascending from 0, rest random, or scrambled
    task automatic load_profile(input int n, input bit broken);
        int unsigned a;
        int unsigned lim;
        a = 0;
        for (int i = 0; i < rati_pkg::MAX_POINTS; i++) begin
            if (broken) begin
                a = $urandom_range(0, 65535);
            end else if (i > 0 && i < n) begin
                lim = (65535 - a) - (n - 1 - i);
                a = a + $urandom_range(1, (lim / (n - i)) * 2 > lim ? lim
                                          : ((lim / (n - i)) * 2 < 1 ? 1 : (lim / (n - i)) * 2));
            end else if (i >= n) begin
                a = $urandom;
            end
            load_point(i[3:0], a[15:0], rnd24());
        end
    endtask

    initial begin
        int                         n;
        int unsigned                w;
        logic [rati_pkg::RAD_W-1:0] inner;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sinusoid extremes, rim wider than radius, band edges
        cfg_write(rati_pkg::REG_OUTER_RADIUS, 24'd1000);
        cfg_write(rati_pkg::REG_RIM_WIDTH, 24'd2000);
        cfg_write(rati_pkg::REG_PEAK_TEMP, 24'hFFFFFF);
        cfg_write(rati_pkg::REG_FLOOR_TEMP, 24'h000000);
        cfg_write(rati_pkg::REG_PEAK_ANGLE, 24'h001234);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        eval_at(24'd0, 16'h0000);
        eval_at(24'd1000, 16'h1234);
        eval_at(24'd1001, 16'h4000);
        eval_at(24'hFFFFFF, 16'h8000);
        eval_at(24'd500, 16'h9234);
        eval_at(24'd999, 16'hFFFF);

        // full breakpoint store, then point mode at both extremes of the count
        for (int i = 0; i < rati_pkg::MAX_POINTS; i++)
            load_point(i[3:0], (i == 15) ? 16'hFFFF : 16'(i * 4096),
                       (i == 3) ? 24'hFFFFFF : ((i == 7) ? 24'h0 : 24'($urandom)));
        wait_drained();
        cfg_write(rati_pkg::REG_RIM_MODE, 24'(rati_pkg::MODE_POINT));
        cfg_write(rati_pkg::REG_POINT_COUNT, 24'd16);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        eval_at(24'd10, 16'h0000);
        eval_at(24'd10, 16'hFFFE);
        eval_at(24'd10, 16'hFFFF);
        eval_at(24'd10, 16'h7FFF);
        wait_drained();
        cfg_write(rati_pkg::REG_POINT_COUNT, 24'd1);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        eval_at(24'd10, 16'h5555);

        // random phases, settings changed only when drained
        for (int ph = 0; ph < 12; ph++) begin
            wait_drained();
            no_idle = (ph % 4 == 3);
            cfg_write(rati_pkg::REG_RIM_MODE, 24'(ph[0]));
            cfg_write(rati_pkg::REG_OUTER_RADIUS, rnd24());
            cfg_write(rati_pkg::REG_RIM_WIDTH,
                      ($urandom_range(0, 3) == 0) ? rnd24() : 24'($urandom_range(0, 4095)));
            cfg_write(rati_pkg::REG_PEAK_TEMP, rnd24());
            cfg_write(rati_pkg::REG_FLOOR_TEMP, rnd24());
            cfg_write(rati_pkg::REG_PEAK_ANGLE, 24'($urandom_range(0, 65535)));
            n = (ph % 3 == 0) ? 16 : ((ph % 5 == 2) ? 1 : $urandom_range(1, 16));
            cfg_write(rati_pkg::REG_POINT_COUNT, 24'(n));
            cfg_we <= 1'b0;
            @(posedge i_clk);
            if (ph[0]) load_profile(n, $urandom_range(0, 6) == 0);
            inner = (sb.band_w > sb.outer_r) ? 24'd0 : sb.outer_r - sb.band_w;
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(0, 19) == 0)
                    load_point(4'($urandom), 16'($urandom), rnd24());
                else if ($urandom_range(0, 9) < 7)
                    eval_at(24'($urandom_range(sb.outer_r, inner)), 16'($urandom));
                else
                    eval_at(rnd24(), 16'($urandom));
            end
        end

        // drain, with a limit
        s_valid <= 1'b0;
        w = 0;
        while (sb.want_q.size() != 0 && w < 200000) begin
            @(posedge i_clk);
            w++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.want_q.size() != 0) begin
            sb.n_mismatch++;
            $display("%0d expected results never arrived", sb.want_q.size());
        end
        $display("Covered %0d transactions: %0d sinusoid and %0d breakpoint evaluates, %0d with no segment.",
                 n_sent, sb.n_sine, sb.n_point, sb.n_nomatch);
        $display("%0d results checked across %0d register writes, with random stalls on both sides.",
                 sb.n_checked, n_cfg);
        if (sb.n_mismatch == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
